// ----- hdl/asl_pkg.sv -----
package asl_pkg;
  localparam int unsigned NumProcs = 32;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned KeyW     = 32;

  typedef enum logic [1:0] {
    KindBlock  = 2'd0,
    KindRmHead = 2'd1,
    KindRmProc = 2'd2,
    KindPeek   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StMissing = 2'd2,
    StBlocked = 2'd3
  } status_e;

  // result word handed to the output register
  typedef struct packed {
    logic            valid;
    status_e         status;
    logic            found;
    logic [IdxW-1:0] proc_id;
  } result_t;
endpackage

// ----- hdl/asl_match.sv -----
// Key match and free-slot search over the descriptor key and valid registers.
module asl_match import asl_pkg::*; (
  input  logic [NumProcs-1:0]        valid_i,
  input  logic [NumProcs-1:0][KeyW-1:0] keys_i,
  input  logic [KeyW-1:0]            key_i,
  output logic                       hit_o,
  output logic [IdxW-1:0]            hit_idx_o,
  output logic                       free_o,
  output logic [IdxW-1:0]            free_idx_o
);
  logic [NumProcs-1:0] hits;

  always_comb begin
    for (int i = 0; i < NumProcs; i++) begin
      hits[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

  // a key sits in at most one descriptor, so an or-reduce encode suffices
  always_comb begin
    hit_idx_o = '0;
    for (int i = 0; i < NumProcs; i++) begin
      if (hits[i]) hit_idx_o = hit_idx_o | IdxW'(i);
    end
  end
  assign hit_o = |hits;

  // lowest free descriptor
  always_comb begin
    free_idx_o = '0;
    for (int i = NumProcs - 1; i >= 0; i--) begin
      if (!valid_i[i]) free_idx_o = IdxW'(i);
    end
  end
  assign free_o = ~&valid_i;
endmodule

// ----- hdl/semaphore_blocked_queue_table_top.sv -----
// Semaphore queue table: a word is taken at a rising edge with start high and
// busy low, and each word gives exactly one result word, shown for a single
// cycle with done_o in the first cycle that busy is low again. There is no
// way to hold a result back, so done_o must be sampled on every edge. Words
// the flags alone settle finish in SMatch: already blocked, new descriptor,
// no free descriptor, unknown key and process not blocked. A block onto an
// existing queue runs SMatch then SWrite (tail read, link write) and a peek
// SMatch then SHead (head read). Remove-head runs SMatch, SHead, SWrite (head
// read, link read, write back) and remove-process SMatch, SDesc, SWrite (link
// read, head/tail read, write back). The next word may be taken in the cycle
// that shows the result. With as many descriptors as processes the table
// never runs out of descriptors. Descriptor keys and the flags sit in
// registers; head, tail and per-process links live in memories read via registers.
module semaphore_blocked_queue_table_top import asl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      kind_i,
  input  logic [31:0]     sem_key_i,
  input  logic [4:0]      proc_id_i,
  output logic            done_o,
  output logic [1:0]      status_o,
  output logic            found_o,
  output logic [4:0]      out_proc_o
);
  typedef enum logic [2:0] {SIdle, SMatch, SHead, SDesc, SWrite} state_e;

  state_e state_q;
  kind_e kind_q;
  logic [KeyW-1:0] key_q;
  logic [IdxW-1:0] proc_q, desc_q, tgt_q;
  logic [NumProcs-1:0] dvalid_q, blocked_q;
  logic [NumProcs-1:0][KeyW-1:0] dkey_q;
  logic hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;
  result_t res_q;

  // memories
  logic [IdxW-1:0] head_m [NumProcs];
  logic [IdxW-1:0] tail_m [NumProcs];
  logic [IdxW-1:0] next_m [NumProcs];
  logic [IdxW-1:0] prev_m [NumProcs];
  logic [IdxW-1:0] pdesc_m [NumProcs];
  logic [IdxW-1:0] head_rd, tail_rd, pdesc_rd, next_rd, prev_rd;
  logic [IdxW-1:0] rd_desc, rd_proc;

  asl_match u_match (
    .valid_i(dvalid_q), .keys_i(dkey_q), .key_i(key_q),
    .hit_o(hit), .hit_idx_o(hit_idx), .free_o(free), .free_idx_o(free_idx)
  );

  assign busy = (state_q != SIdle);

  // read addresses: matched descriptor, then the owner of a removal target
  assign rd_desc = (state_q == SDesc) ? pdesc_rd : hit_idx;
  assign rd_proc = (state_q == SHead) ? head_rd : proc_q;

  // descriptor and process link reads
  always_ff @(posedge clk_i) begin
    if (state_q == SMatch || state_q == SDesc) begin
      head_rd <= head_m[rd_desc];
      tail_rd <= tail_m[rd_desc];
    end
    if (state_q == SMatch || state_q == SHead) begin
      pdesc_rd <= pdesc_m[rd_proc];
      next_rd  <= next_m[rd_proc];
      prev_rd  <= prev_m[rd_proc];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      state_q   <= SIdle;
      kind_q    <= KindBlock;
      key_q     <= '0;
      proc_q    <= '0;
      desc_q    <= '0;
      tgt_q     <= '0;
      dvalid_q  <= '0;
      blocked_q <= '0;
      dkey_q    <= '0;
      res_q     <= '0;
    end else begin
      res = '0;
      unique case (state_q)
        SIdle: begin
          if (start) begin
            kind_q  <= kind_e'(kind_i);
            key_q   <= sem_key_i;
            proc_q  <= proc_id_i;
            state_q <= SMatch;
          end
        end
        // match key; finish words settled by the flags here
        SMatch: begin
          unique case (kind_q)
            KindBlock: begin
              if (blocked_q[proc_q]) begin
                res     = '{1'b1, StBlocked, 1'b0, '0};
                state_q <= SIdle;
              end else if (hit) begin
                desc_q  <= hit_idx;
                state_q <= SWrite;
              end else if (free) begin
                dvalid_q[free_idx] <= 1'b1;
                dkey_q[free_idx]   <= key_q;
                blocked_q[proc_q]  <= 1'b1;
                res     = '{1'b1, StOk, 1'b0, '0};
                state_q <= SIdle;
              end else begin
                res     = '{1'b1, StFull, 1'b0, '0};
                state_q <= SIdle;
              end
            end
            KindRmHead, KindPeek: begin
              if (hit) begin
                state_q <= SHead;
              end else begin
                res     = '{1'b1, StMissing, 1'b0, '0};
                state_q <= SIdle;
              end
            end
            KindRmProc: begin
              if (blocked_q[proc_q]) begin
                tgt_q   <= proc_q;
                state_q <= SDesc;
              end else begin
                res     = '{1'b1, StMissing, 1'b0, '0};
                state_q <= SIdle;
              end
            end
          endcase
        end
        // head of the matched queue is on head_rd
        SHead: begin
          if (kind_q == KindPeek) begin
            res     = '{1'b1, StOk, 1'b1, head_rd};
            state_q <= SIdle;
          end else begin
            tgt_q   <= head_rd;
            state_q <= SWrite;
          end
        end
        // owner of the target known; head/tail of it being read
        SDesc: state_q <= SWrite;
        SWrite: begin
          if (kind_q == KindBlock) begin
            blocked_q[proc_q] <= 1'b1;
            res = '{1'b1, StOk, 1'b0, '0};
          end else begin
            blocked_q[tgt_q] <= 1'b0;
            if (tgt_q == head_rd && tgt_q == tail_rd) dvalid_q[pdesc_rd] <= 1'b0;
            res = '{1'b1, StOk, 1'b1, tgt_q};
          end
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
      res_q <= res;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    // fresh descriptor for a block word
    if (state_q == SMatch && kind_q == KindBlock && !blocked_q[proc_q] &&
        !hit && free) begin
      head_m[free_idx] <= proc_q;
      tail_m[free_idx] <= proc_q;
      pdesc_m[proc_q]  <= free_idx;
    end
    if (state_q == SWrite) begin
      if (kind_q == KindBlock) begin
        next_m[tail_rd] <= proc_q;
        prev_m[proc_q]  <= tail_rd;
        tail_m[desc_q]  <= proc_q;
        pdesc_m[proc_q] <= desc_q;
      end else if (tgt_q == head_rd && tgt_q != tail_rd) begin
        head_m[pdesc_rd] <= next_rd;
      end else if (tgt_q == tail_rd && tgt_q != head_rd) begin
        tail_m[pdesc_rd] <= prev_rd;
      end else if (tgt_q != head_rd) begin
        // middle of the queue: splice both neighbours
        next_m[prev_rd] <= next_rd;
        prev_m[next_rd] <= prev_rd;
      end
    end
  end

  assign done_o     = res_q.valid;
  assign status_o   = res_q.status;
  assign found_o    = res_q.found;
  assign out_proc_o = res_q.proc_id;

  // result strobe only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without item");
  // found implies ok
  assert property (@(posedge clk_i) disable iff (!rst_ni) (done_o && found_o) |->
    status_o == StOk) else $error("found with bad status");
  // block never reports a process
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && kind_q == KindBlock) |-> !found_o)
    else $error("block reported process");
endmodule
